### rtl/core/ecl_pkg.sv
// Shared types and constants for the epsilon cycle limiter.
// Used by ecl_front, ecl_back and epsilon_cycle_limiter_top; depends on nothing.
`default_nettype none

package ecl_pkg;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned CYCLE_W = 17;
  localparam logic [CYCLE_W-1:0] COUNT_MAX = 17'h1FFFF;
  localparam int unsigned DEPTH_OUT_W = 7;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] state_id;
  } in_item_t;

  typedef struct packed {
    logic                   may_continue;
    logic                   cycle_found;
    logic                   overflow;
    logic [DEPTH_OUT_W-1:0] path_depth;
  } out_item_t;

  // One decoded command waiting for the back end.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] state_id;
  } task_t;

endpackage

`default_nettype wire

### rtl/core/ecl_front.sv
// Front end: accepts input items, decodes the action and queues commands.
// Depends on ecl_pkg.
`default_nettype none

module ecl_front
  import ecl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          task_valid,
  input  wire logic     task_ready,
  output task_t         task_out
);

  task_t      queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  task_t      decoded;
  logic       push_en;
  logic       pop_en;

  always_comb begin
    decoded.state_id = in_item.state_id;
    unique case (in_item.action)
      ACT_PUSH:  decoded.op = ACT_PUSH;
      ACT_POP:   decoded.op = ACT_POP;
      ACT_CHECK: decoded.op = ACT_CHECK;
      default:   decoded.op = ACT_NOP;
    endcase
  end

  assign in_ready   = (fill != 2'd2);
  assign task_valid = (fill != 2'd0);
  assign task_out   = queue[rd_ptr];
  assign push_en    = in_valid && in_ready;
  assign pop_en     = task_valid && task_ready;

  always_ff @(posedge clk) begin
    if (push_en) begin
      queue[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_en && !pop_en) begin
        fill <= fill + 2'd1;
      end else if (pop_en && !push_en) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/ecl_back.sv
// Back end: path stack memory, search sequencer, cycle counter and result register.
// Depends on ecl_pkg.
`default_nettype none

module ecl_back
  import ecl_pkg::*;
#(
  parameter int unsigned PATH_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               task_valid,
  output logic                    task_ready,
  input  wire task_t              task_in,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_limit,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_item
);

  localparam int unsigned AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PATH_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PUSH = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [31:0]        mem [PATH_DEPTH];
  logic [31:0]        rd_data;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;

  logic [1:0]         state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      pop_count;
  logic [CYCLE_W-1:0] cycle_count;
  logic [CYCLE_W-1:0] cycle_next;
  logic [LIMIT_W-1:0] cycle_limit;
  logic [31:0]        sid;
  out_item_t          res;
  logic               out_free;
  logic               top_same;
  logic               full;
  logic               go;

  assign task_ready = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign top_same   = (count != '0) && (rd_data == sid);
  assign full       = (count == CW'(PATH_DEPTH));
  assign mem_we     = (state == S_PUSH) && !top_same && !full;
  assign pop_count  = (count != '0) ? count - 1'b1 : count;
  assign cycle_next = (cycle_count == COUNT_MAX) ? cycle_count : cycle_count + 1'b1;
  assign go         = !(cycle_next > {1'b0, cycle_limit});

  // The scan keeps one read in flight: idx names the entry now in rd_data.
  always_comb begin
    if (state == S_SCAN) begin
      rd_addr = AW'(idx + 1'b1);
    end else if (task_in.op == ACT_PUSH) begin
      rd_addr = AW'(count - 1'b1);
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(count)] <= sid;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_limit <= '0;
    end else if (cfg_we) begin
      cycle_limit <= cfg_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      cycle_count <= '0;
      idx         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (task_valid) begin
            sid <= task_in.state_id;
            idx <= '0;
            unique case (task_in.op)
              ACT_PUSH: begin
                state <= S_PUSH;
              end
              ACT_CHECK: begin
                state <= S_SCAN;
              end
              ACT_POP: begin
                count <= pop_count;
                res   <= '{may_continue: 1'b1, cycle_found: 1'b0, overflow: 1'b0,
                           path_depth: DEPTH_OUT_W'(pop_count)};
                state <= S_DONE;
              end
              ACT_NOP: begin
                res   <= '{may_continue: 1'b1, cycle_found: 1'b0, overflow: 1'b0,
                           path_depth: DEPTH_OUT_W'(count)};
                state <= S_DONE;
              end
            endcase
          end
        end
        S_PUSH: begin
          if (mem_we) begin
            count <= count + 1'b1;
            res   <= '{may_continue: 1'b1, cycle_found: 1'b0, overflow: 1'b0,
                       path_depth: DEPTH_OUT_W'(count + 1'b1)};
          end else begin
            res   <= '{may_continue: 1'b1, cycle_found: 1'b0,
                       overflow: !top_same, path_depth: DEPTH_OUT_W'(count)};
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          if (idx >= count) begin
            res   <= '{may_continue: 1'b1, cycle_found: 1'b0, overflow: 1'b0,
                       path_depth: DEPTH_OUT_W'(count)};
            state <= S_DONE;
          end else if (rd_data == sid) begin
            // First match from the bottom: cut the stack back to it.
            count       <= idx + 1'b1;
            cycle_count <= cycle_next;
            res         <= '{may_continue: go, cycle_found: 1'b1, overflow: 1'b0,
                             path_depth: DEPTH_OUT_W'(idx + 1'b1)};
            state       <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

### rtl/core/epsilon_cycle_limiter_top.sv
// Top level of the epsilon cycle limiter: front end queue plus back end sequencer.
// Depends on ecl_pkg, ecl_front and ecl_back.
`default_nettype none

// Tracks a stack of automaton states along an epsilon path and counts the
// cycles found on it. Each transfer on the input channel carries one action
// (push, pop, check) and produces exactly one transfer on the output channel.
// A two-entry command queue in front lets the input keep moving while the
// back end works. A pop or no-op goes from the queue through the back end's
// result register into the output register; a push first does one stack
// memory read to compare against the top, and a check scans the stack from
// the bottom to the first match, or through the full stack depth when nothing
// matches: the back end reads one stack entry per cycle through the single
// memory read port. The back end takes the next command as soon as its result
// has moved into the output register, so a result held by the receiver stalls
// the back end and then fills the queue.
// The cycle limit register is written through the configuration channel,
// which is always ready; write it only while the block is idle.
module epsilon_cycle_limiter_top
  import ecl_pkg::*;
#(
  parameter int unsigned PATH_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data
);

  logic  task_valid;
  logic  task_ready;
  task_t task_cmd;

  assign cfg_ready = 1'b1;

  ecl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .task_valid (task_valid),
    .task_ready (task_ready),
    .task_out   (task_cmd)
  );

  ecl_back #(
    .PATH_DEPTH (PATH_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .task_valid (task_valid),
    .task_ready (task_ready),
    .task_in    (task_cmd),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_limit  (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

### tb/sv/epsilon_cycle_limiter_checker.sv
// Checker for the epsilon cycle limiter: watches the input, output and
// configuration channels, tracks its own copy of the path stack and cycle count.
// Depends on ecl_pkg for the payload types and action codes.
module epsilon_cycle_limiter_checker
  import ecl_pkg::*;
#(
  parameter int unsigned PATH_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_item_t           in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_item_t          out_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]        path_copy [PATH_DEPTH];
  int                 path_len;
  logic [CYCLE_W-1:0] loop_tally;
  logic [LIMIT_W-1:0] loop_ceiling;
  out_item_t          awaited_answers [$];

  task automatic report_mismatch(input string what);
    $display("%0t ns checker: %s", $realtime, what);
    mismatches++;
  endtask

  // Applies one action to the tracked path and returns the answer it must produce.
  task automatic apply_path_action(input in_item_t act_item, output out_item_t answer);
    logic hit;
    answer.may_continue = 1'b1;
    answer.cycle_found  = 1'b0;
    answer.overflow     = 1'b0;
    hit = 1'b0;
    case (act_item.action)
      ACT_PUSH: begin
        if (path_len > 0 && path_copy[path_len-1] == act_item.state_id) begin
          // The same state is already on top; nothing changes.
        end else if (path_len >= PATH_DEPTH) begin
          answer.overflow = 1'b1;
        end else begin
          path_copy[path_len] = act_item.state_id;
          path_len++;
        end
      end
      ACT_POP: begin
        if (path_len > 0) path_len--;
      end
      ACT_CHECK: begin
        for (int i = 0; i < path_len && !hit; i++) begin
          if (path_copy[i] == act_item.state_id) begin
            hit = 1'b1;
            path_len = i + 1;
            if (loop_tally < COUNT_MAX) loop_tally++;
            answer.cycle_found  = 1'b1;
            answer.may_continue = (loop_tally > {1'b0, loop_ceiling}) ? 1'b0 : 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    answer.path_depth = path_len[DEPTH_OUT_W-1:0];
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      path_len     = 0;
      loop_tally   = '0;
      loop_ceiling = '0;
      mismatches   = 0;
      awaited_answers.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch("result transfer with no answer awaited");
        end else begin
          want = awaited_answers.pop_front();
          if (out_item.may_continue !== want.may_continue)
            report_mismatch($sformatf("may_continue got %b want %b",
                                      out_item.may_continue, want.may_continue));
          if (out_item.cycle_found !== want.cycle_found)
            report_mismatch($sformatf("cycle_found got %b want %b",
                                      out_item.cycle_found, want.cycle_found));
          if (out_item.overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %b want %b",
                                      out_item.overflow, want.overflow));
          if (out_item.path_depth !== want.path_depth)
            report_mismatch($sformatf("path_depth got %0d want %0d",
                                      out_item.path_depth, want.path_depth));
        end
      end
      if (cfg_valid && cfg_ready) loop_ceiling = cfg_data;
      if (in_valid && in_ready) begin
        apply_path_action(in_item, want);
        awaited_answers.insert(awaited_answers.size(), want);
      end
    end
    outstanding <= awaited_answers.size();
  end

endmodule

### tb/sv/epsilon_cycle_limiter_top_tb.sv
// Testbench top for the epsilon cycle limiter: clock, reset, stimulus and verdict.
// Depends on ecl_pkg, epsilon_cycle_limiter_top and epsilon_cycle_limiter_checker.
module epsilon_cycle_limiter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ecl_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 100;
  localparam int SAT_CHECKS  = 60;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  in_item_t           in_item   = '0;
  logic               in_ready;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_item;
  logic               cfg_valid = 1'b0;
  logic [LIMIT_W-1:0] cfg_data  = '0;
  logic               cfg_ready;
  int                 mismatches;
  int                 outstanding;

  logic               rx_calm = 1'b0;
  int                 ready_mode;
  int                 mode_left;
  int                 rx_tick;
  int                 quiet_cycles;
  int                 burst_left = 0;
  int                 gap_max = 4;
  int                 checks_sent = 0;
  logic [31:0]        state_pool [8];

  epsilon_cycle_limiter_top #(
    .PATH_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  epsilon_cycle_limiter_checker #(
    .PATH_DEPTH(DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver switches at random between stall patterns.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_mode <= 0;
      mode_left  <= 0;
      rx_tick    <= 0;
    end else if (rx_calm) begin
      out_ready <= 1'b1;
    end else begin
      rx_tick <= rx_tick + 1;
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((rx_tick % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one action; bursts of transfers are separated by random gaps.
  task automatic send_action(input logic [1:0] act, input logic [31:0] sid);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_item  <= '{action: act, state_id: sid};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (act == ACT_CHECK) checks_sent++;
  endtask

  // Lets every awaited answer arrive; the first edge lets the checker see the last transfer.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic refill_pool();
    foreach (state_pool[i]) state_pool[i] = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      state_pool[0] = 32'h0000_0000;
      state_pool[1] = 32'hFFFF_FFFF;
    end
  endtask

  // Mostly pushes and checks drawn from a small pool of states, so that
  // checks find cycles and pushes repeat the top; the rest are random states.
  task automatic run_path_phase(input int count, input int push_w, input int pop_w,
                                input int check_w);
    int r;
    refill_pool();
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < push_w)
        send_action(ACT_PUSH, ($urandom_range(0, 9) == 0) ? $urandom
                                                           : state_pool[$urandom_range(0, 7)]);
      else if (r < push_w + pop_w)
        send_action(ACT_POP, $urandom);
      else if (r < push_w + pop_w + check_w)
        send_action(ACT_CHECK, ($urandom_range(0, 4) == 0) ? $urandom
                                                            : state_pool[$urandom_range(0, 7)]);
      else
        send_action(ACT_NOP, $urandom);
    end
  endtask

  initial begin
    int lo;
    int hi;
    int pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // With a limit of one, the first cycle is allowed and the second refused.
    write_limit(16'd1);
    send_action(ACT_POP, 32'h0000_0000);
    send_action(ACT_CHECK, 32'h0000_0000);
    send_action(ACT_NOP, 32'hFFFF_FFFF);
    send_action(ACT_PUSH, 32'h0000_0000);
    send_action(ACT_PUSH, 32'h0000_0000);
    send_action(ACT_PUSH, 32'hFFFF_FFFF);
    send_action(ACT_PUSH, 32'hFFFF_FFFF);
    send_action(ACT_PUSH, 32'h1234_5678);
    send_action(ACT_CHECK, 32'h0000_0099);
    send_action(ACT_CHECK, 32'hFFFF_FFFF);
    send_action(ACT_PUSH, 32'hAAAA_AAAA);
    send_action(ACT_PUSH, 32'h5555_5555);
    send_action(ACT_CHECK, 32'h0000_0000);
    send_action(ACT_POP, 32'hFFFF_FFFF);
    send_action(ACT_POP, 32'h0000_0000);
    send_action(ACT_NOP, 32'h0000_0000);
    send_action(ACT_PUSH, 32'h5555_5555);
    send_action(ACT_CHECK, 32'h5555_5555);
    send_action(ACT_POP, 32'h0000_0000);

    // Fill the stack, then overflow it and search it end to end.
    for (int i = 0; i < DEPTH; i++) send_action(ACT_PUSH, 32'hC3A5_0000 ^ i);
    send_action(ACT_PUSH, 32'h0F0F_0F0F);
    send_action(ACT_PUSH, 32'hC3A5_0000 ^ (DEPTH - 1));
    send_action(ACT_CHECK, 32'h0000_FFFF);
    send_action(ACT_CHECK, 32'hC3A5_0000 ^ (DEPTH - 1));
    send_action(ACT_POP, 32'h0000_0000);
    send_action(ACT_PUSH, 32'h7777_7777);
    send_action(ACT_PUSH, 32'h8888_8888);
    send_action(ACT_CHECK, 32'hC3A5_0000);

    write_limit(16'd0);
    gap_max = 6;
    run_path_phase(200, 60, 15, 20);

    write_limit(16'hFFFF);
    gap_max = 0;
    run_path_phase(200, 80, 10, 8);

    for (int p = 0; p < 5; p++) begin
      lo = checks_sent / 4;
      hi = checks_sent + 50;
      if (hi > 65535) hi = 65535;
      write_limit(LIMIT_W'($urandom_range(hi, lo)));
      gap_max = $urandom_range(0, 10);
      pick = $urandom_range(0, 2);
      case (pick)
        0:       run_path_phase(150, 50, 15, 30);
        1:       run_path_phase(150, 75, 10, 12);
        default: run_path_phase(150, 40, 25, 30);
      endcase
    end

    // Noise: every action code and fully random states.
    write_limit(LIMIT_W'($urandom));
    gap_max = 8;
    for (int n = 0; n < 200; n++) send_action(2'($urandom_range(0, 3)), $urandom);

    // Back-to-back checks that match at the bottom of a one-entry stack,
    // with the receiver always ready.
    write_limit(16'hFFFF);
    gap_max = 0;
    rx_calm <= 1'b1;
    for (int n = 0; n < DEPTH + 6; n++) send_action(ACT_POP, $urandom);
    send_action(ACT_PUSH, 32'h5A5A_A5A5);
    for (int n = 0; n < SAT_CHECKS; n++) send_action(ACT_CHECK, 32'h5A5A_A5A5);

    // The count found so far against a fresh random limit.
    write_limit(LIMIT_W'($urandom));
    rx_calm <= 1'b0;
    gap_max = 5;
    run_path_phase(100, 50, 15, 30);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
